// ===== design/vector_clock_min_tracker_core_macros.svh =====
`ifndef VECTOR_CLOCK_MIN_TRACKER_CORE_MACROS_SVH
`define VECTOR_CLOCK_MIN_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define VCMT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vcmt assertion failed");

// next-cycle implication, checked outside reset
`define VCMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vcmt assertion failed");

`endif

// ===== design/vcmt_pkg.sv =====
package vcmt_pkg;

	localparam int ID_W            = 6;
	localparam int ID_SPACE        = 64;
	localparam int CLK_W           = 31;
	localparam int MIN_W           = 32;
	localparam int OP_W            = 2;
	localparam int IN_W            = 40;
	localparam int OUT_W           = 104;
	localparam int MAX_WORKERS_DEF = 64;

	localparam logic [CLK_W-1:0] CLK_MAX   = {CLK_W{1'b1}};
	localparam logic [MIN_W-1:0] MIN_EMPTY = {MIN_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ADD        = 2'd0,
		OP_TICK       = 2'd1,
		OP_TICK_UNTIL = 2'd2,
		OP_QUERY      = 2'd3
	} op_t;

	typedef struct packed {
		logic             start;
		logic [ID_W-1:0]  self_id;
		logic [CLK_W-1:0] m;
	} scan_ctrl_t;

	typedef struct packed {
		logic             done;
		logic             found_eq;
		logic             nx_vld;
		logic [CLK_W-1:0] nx;
	} scan_stat_t;

endpackage

// ===== design/vcmt_clock_mem.sv =====
module vcmt_clock_mem
	import vcmt_pkg::*;
#(
	parameter int DEPTH = MAX_WORKERS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [CLK_W-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [CLK_W-1:0] rdata
);

	logic [CLK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/vcmt_scan.sv =====
module vcmt_scan
	import vcmt_pkg::*;
#(
	parameter int DEPTH = MAX_WORKERS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctrl_t       ctrl,
	input  logic [DEPTH-1:0] valid,
	input  logic [CLK_W-1:0] rdata,
	output logic [AW-1:0]    raddr,
	output logic             busy,
	output scan_stat_t       stat
);

	logic             busy_q;
	logic [AW-1:0]    idx_q;
	logic             chk_s1;
	logic             last_s1;
	logic [AW-1:0]    chk_idx_s1;
	logic             found_q;
	logic             nxv_q;
	logic [CLK_W-1:0] nx_q;
	logic             done_q;
	logic             idx_last;
	logic             hit;

	assign idx_last = (idx_q == AW'(DEPTH - 1));
	assign hit      = chk_s1 && valid[chk_idx_s1] && (chk_idx_s1 != ctrl.self_id[AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			chk_s1  <= 1'b0;
			last_s1 <= 1'b0;
			found_q <= 1'b0;
			nxv_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q     <= chk_s1 && last_s1;
			chk_s1     <= busy_q;
			last_s1    <= idx_last;
			chk_idx_s1 <= idx_q;
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				idx_q   <= '0;
				found_q <= 1'b0;
				nxv_q   <= 1'b0;
			end else begin
				if (busy_q) begin
					idx_q <= idx_q + AW'(1);
					if (idx_last) begin
						busy_q <= 1'b0;
					end
				end
				if (hit) begin
					if (rdata == ctrl.m) begin
						found_q <= 1'b1;
					end else if (rdata > ctrl.m && (!nxv_q || rdata < nx_q)) begin
						nx_q  <= rdata;
						nxv_q <= 1'b1;
					end
				end
			end
		end
	end

	assign raddr         = idx_q;
	assign busy          = busy_q;
	assign stat.done     = done_q;
	assign stat.found_eq = found_q;
	assign stat.nx_vld   = nxv_q;
	assign stat.nx       = nx_q;

endmodule

// ===== design/vector_clock_min_tracker_core.sv =====
// Path from accept to m_axis_tvalid: an id at or above MAX_WORKERS goes straight to the output
// state; add, query, a dropped tick and a tick-until with no work read the clock table and
// finish; a tick or tick-until that cannot raise the minimum also passes the check state;
// otherwise the min(MAX_WORKERS, 64) table entries are scanned, one entry per cycle.
// Throughput: one transaction at a time; s_axis_tready rises with m_axis_tvalid. Reset:
// arst_n clears the valid map, sets the tracked minimum to -1, empties the output.
`include "vector_clock_min_tracker_core_macros.svh"

module vector_clock_min_tracker_core
	import vcmt_pkg::*;
#(
	parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] operation, [7:2] worker_id, [38:8] clock_value, [39] zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [30:0] returned_min, [31] min_advanced, [62:32] entry_clock,
	// [94:63] cur_min, [95] unknown_id, [96] overflow, [103:97] zero
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int DEPTH = (MAX_WORKERS < ID_SPACE) ? MAX_WORKERS : ID_SPACE;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_CHK,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [DEPTH-1:0] valid_q;
	logic [MIN_W-1:0] min_q;
	op_t              op_q;
	logic [ID_W-1:0]  id_q;
	logic [AW-1:0]    addr_q;
	logic [CLK_W-1:0] cv_q;
	logic [CLK_W-1:0] e0_q;
	logic [CLK_W-1:0] t_q;
	logic [CLK_W-1:0] res_ret_q;
	logic             res_adv_q;
	logic [CLK_W-1:0] res_ec_q;
	logic             res_unk_q;
	logic             res_ovf_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic             in_acc;
	logic             id_ok;
	logic             vld;
	logic [CLK_W-1:0] e0;
	logic             run_cond;
	logic [CLK_W-1:0] m_new;

	logic             mem_we;
	logic [CLK_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [CLK_W-1:0] mem_rdata;

	scan_ctrl_t       scan_ctrl;
	scan_stat_t       scan_stat;
	logic [AW-1:0]    scan_raddr;
	logic             scan_busy;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign id_ok         = (32'(s_axis_tdata[7:2]) < 32'(MAX_WORKERS));

	assign vld      = valid_q[addr_q];
	assign e0       = vld ? mem_rdata : '0;
	assign run_cond = !min_q[MIN_W-1] && (e0_q <= min_q[CLK_W-1:0])
		&& (t_q > min_q[CLK_W-1:0]);
	assign m_new    = (scan_stat.nx_vld && scan_stat.nx < t_q) ? scan_stat.nx : t_q;
	assign mem_raddr = scan_busy ? scan_raddr : addr_q;

	always_comb begin
		mem_we            = 1'b0;
		mem_wdata         = t_q;
		scan_ctrl.start   = 1'b0;
		scan_ctrl.self_id = id_q;
		scan_ctrl.m       = min_q[CLK_W-1:0];
		case (state_q)
			ST_EVAL: begin
				case (op_q)
					OP_ADD: begin
						mem_we    = 1'b1;
						mem_wdata = cv_q;
					end
					OP_TICK_UNTIL: begin
						if (!(cv_q > e0) && !vld) begin
							mem_we    = 1'b1;
							mem_wdata = '0;
						end
					end
					default: begin
					end
				endcase
			end
			ST_CHK: begin
				if (run_cond) begin
					scan_ctrl.start = 1'b1;
				end else begin
					mem_we = 1'b1;
				end
			end
			ST_SCAN: begin
				mem_we = scan_stat.done;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			min_q      <= MIN_EMPTY;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_axis_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q      <= op_t'(s_axis_tdata[1:0]);
						id_q      <= s_axis_tdata[7:2];
						addr_q    <= s_axis_tdata[2 +: AW];
						cv_q      <= s_axis_tdata[38:8];
						res_ret_q <= '0;
						res_adv_q <= 1'b0;
						res_ec_q  <= '0;
						res_ovf_q <= 1'b0;
						res_unk_q <= !id_ok;
						state_q   <= id_ok ? ST_RD : ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					e0_q <= e0;
					case (op_q)
						OP_ADD: begin
							valid_q[addr_q] <= 1'b1;
							res_ec_q        <= cv_q;
							state_q         <= ST_DONE;
							if (min_q == MIN_EMPTY || $signed({1'b0, cv_q}) < $signed(min_q)) begin
								min_q <= {1'b0, cv_q};
							end
						end
						OP_TICK: begin
							valid_q[addr_q] <= 1'b1;
							res_ec_q        <= e0;
							if (e0 == CLK_MAX) begin
								res_ovf_q <= 1'b1;
								state_q   <= ST_DONE;
							end else begin
								t_q     <= e0 + CLK_W'(1);
								state_q <= ST_CHK;
							end
						end
						OP_TICK_UNTIL: begin
							valid_q[addr_q] <= 1'b1;
							res_ec_q        <= e0;
							if (cv_q > e0) begin
								t_q     <= cv_q;
								state_q <= ST_CHK;
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: begin
							res_ec_q  <= e0;
							res_unk_q <= !vld;
							state_q   <= ST_DONE;
						end
					endcase
				end
				ST_CHK: begin
					res_ec_q <= t_q;
					state_q  <= run_cond ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						if (!scan_stat.found_eq) begin
							min_q     <= {1'b0, m_new};
							res_ret_q <= m_new;
							res_adv_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'b0, res_ovf_q, res_unk_q, min_q, res_ec_q,
							res_adv_q, res_ret_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	vcmt_clock_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_q),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	vcmt_scan #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (scan_ctrl),
		.valid (valid_q),
		.rdata (mem_rdata),
		.raddr (scan_raddr),
		.busy  (scan_busy),
		.stat  (scan_stat)
	);

	`VCMT_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE)
	`VCMT_ASSERT_IMP(a_scan_done_in_scan, scan_stat.done, state_q == ST_SCAN)
	`VCMT_ASSERT_IMP(a_adv_nonzero, m_axis_tvalid && m_axis_tdata[31], m_axis_tdata[30:0] != 0)
	`VCMT_ASSERT_IMP(a_no_write_while_scan, scan_busy, !mem_we)

endmodule
